[sv/ect_pkg.sv]
// ----------------------------------------------------------------------------
// ect_pkg
// Shared types, character codes and helpers for the expression tokenizer.
// ----------------------------------------------------------------------------
package ect_pkg;

  localparam int CHAR_W     = 8;
  localparam int NUM_W      = 31;
  localparam int MAX_TOKENS = 3;
  localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
  localparam int FIFO_DEPTH = 4;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
  localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_OP1    = 2'd1,
    KIND_OP2    = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [NUM_W-1:0]   number_value;
    logic [CHAR_W-1:0]  op_first;
    logic [CHAR_W-1:0]  op_second;
    logic               overflow;
    logic               last_token;
  } token_t;

  // all tokens caused by one character, in order
  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic   [CNT_W-1:0]      cnt;
  } bundle_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic starts_pair(input logic [CHAR_W-1:0] c);
    return (c == CH_GT) || (c == CH_LT) || (c == CH_BANG) || (c == CH_EQ) ||
           (c == CH_AMP) || (c == CH_BAR) || (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

[sv/ect_char_if.sv]
// ----------------------------------------------------------------------------
// ect_char_if
// Character stream channel: valid/ready plus one character and end flag.
// ----------------------------------------------------------------------------
interface ect_char_if;
  import ect_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              end_of_text;

  modport source (output valid, ch, end_of_text, input ready);
  modport sink   (input valid, ch, end_of_text, output ready);
endinterface

[sv/ect_token_if.sv]
// ----------------------------------------------------------------------------
// ect_token_if
// Token stream channel: valid/ready plus one token.
// ----------------------------------------------------------------------------
interface ect_token_if;
  import ect_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [NUM_W-1:0]  number_value;
  logic [CHAR_W-1:0] op_first;
  logic [CHAR_W-1:0] op_second;
  logic              overflow;
  logic              last_token;

  modport source (output valid, kind, number_value, op_first, op_second, overflow,
                  last_token, input ready);
  modport sink   (input valid, kind, number_value, op_first, op_second, overflow,
                  last_token, output ready);
endinterface

[sv/ect_front.sv]
// ----------------------------------------------------------------------------
// ect_front
// Lexer state machine: classifies each character and builds the bundle of
// tokens it completes (up to three).
// ----------------------------------------------------------------------------
module ect_front (
  input  logic            clk,
  input  logic            rst,
  ect_char_if.sink        chars,
  input  logic            q_ready,
  output logic            push,
  output ect_pkg::bundle_t bundle
);
  import ect_pkg::*;

  typedef enum logic [1:0] {
    P_NONE = 2'd0,
    P_NUM  = 2'd1,
    P_OP   = 2'd2
  } pend_t;

  pend_t             pending_kind, pending_kind_next;
  logic [NUM_W-1:0]  number_accum, number_accum_next;
  logic              number_saturated, number_saturated_next;
  logic [CHAR_W-1:0] pending_op_char, pending_op_char_next;
  logic              prev_was_digit, prev_was_digit_next;
  logic              minus_may_pair, minus_may_pair_next;
  logic              accept;

  function automatic token_t make_tok(input kind_t k, input logic [NUM_W-1:0] v,
                                      input logic [CHAR_W-1:0] a,
                                      input logic [CHAR_W-1:0] b,
                                      input logic ovf, input logic last);
    token_t t;
    t.kind         = k;
    t.number_value = v;
    t.op_first     = a;
    t.op_second    = b;
    t.overflow     = ovf;
    t.last_token   = last;
    return t;
  endfunction

  function automatic token_t pend_tok(input pend_t k, input logic [NUM_W-1:0] v,
                                      input logic ovf, input logic [CHAR_W-1:0] a);
    if (k == P_NUM) return make_tok(KIND_NUMBER, v, '0, '0, ovf, 1'b0);
    return make_tok(KIND_OP1, '0, a, '0, 1'b0, 1'b0);
  endfunction

  assign chars.ready = q_ready;
  assign accept      = chars.valid && q_ready;
  assign push        = accept && (bundle.cnt != '0);

  always_comb begin
    logic [CHAR_W-1:0] c;
    logic [CNT_W-1:0]  n;
    logic              used;
    logic              pairs;
    logic              digit_before;
    logic [NUM_W+3:0]  wide;
    pend_t             nk;
    logic [NUM_W-1:0]  acc;
    logic              sat;
    logic [CHAR_W-1:0] opc;
    logic              pwd;
    logic              mmp;

    c    = chars.ch;
    n    = '0;
    used = 1'b0;
    nk   = pending_kind;
    acc  = number_accum;
    sat  = number_saturated;
    opc  = pending_op_char;
    pwd  = prev_was_digit;
    mmp  = minus_may_pair;
    wide = '0;
    bundle.tok = '0;

    if (nk == P_OP) begin
      if (opc == c) pairs = (opc != CH_MINUS) || mmp;
      else          pairs = (c == CH_EQ) && (opc == CH_BANG || opc == CH_LT || opc == CH_GT);
      if (pairs) begin
        bundle.tok[n] = make_tok(KIND_OP2, '0, opc, c, 1'b0, 1'b0);
        n    = n + CNT_W'(1);
        nk   = P_NONE;
        opc  = '0;
        mmp  = 1'b0;
        pwd  = 1'b0;
        used = 1'b1;
      end else begin
        bundle.tok[n] = pend_tok(nk, acc, sat, opc);
        n   = n + CNT_W'(1);
        nk  = P_NONE;
        acc = '0;
        sat = 1'b0;
        opc = '0;
        mmp = 1'b0;
      end
    end else begin
      pairs = 1'b0;
    end

    digit_before = pwd;
    if (!used) begin
      if (is_space(c)) begin
        if (nk != P_NONE) begin
          bundle.tok[n] = pend_tok(nk, acc, sat, opc);
          n = n + CNT_W'(1);
        end
        nk  = P_NONE;
        acc = '0;
        sat = 1'b0;
        opc = '0;
        mmp = 1'b0;
      end else if (is_digit(c)) begin
        if (nk != P_NUM) begin
          nk  = P_NUM;
          acc = NUM_W'(c - CH_ZERO);
          sat = 1'b0;
        end else begin
          // acc * 10 + digit as two shifted adds
          wide = {3'b000, acc, 1'b0} + {1'b0, acc, 3'b000} + (NUM_W+4)'(c - CH_ZERO);
          if (wide > (NUM_W+4)'(NUM_MAX)) begin
            acc = NUM_MAX;
            sat = 1'b1;
          end else begin
            acc = wide[NUM_W-1:0];
          end
        end
        pwd = 1'b1;
      end else begin
        if (nk != P_NONE) begin
          bundle.tok[n] = pend_tok(nk, acc, sat, opc);
          n = n + CNT_W'(1);
        end
        nk  = P_NONE;
        acc = '0;
        sat = 1'b0;
        opc = '0;
        mmp = 1'b0;
        if (c == CH_MINUS && !digit_before) begin
          bundle.tok[n] = make_tok(KIND_OP1, '0, c, '0, 1'b0, 1'b0);
          n = n + CNT_W'(1);
        end else if (starts_pair(c)) begin
          nk  = P_OP;
          opc = c;
          mmp = (c == CH_MINUS);
        end else begin
          bundle.tok[n] = make_tok(KIND_OP1, '0, c, '0, 1'b0, 1'b0);
          n = n + CNT_W'(1);
        end
        pwd = 1'b0;
      end
    end

    if (chars.end_of_text) begin
      if (nk != P_NONE) begin
        bundle.tok[n] = pend_tok(nk, acc, sat, opc);
        n = n + CNT_W'(1);
      end
      bundle.tok[n] = make_tok(KIND_END, '0, '0, '0, 1'b0, 1'b1);
      n   = n + CNT_W'(1);
      nk  = P_NONE;
      acc = '0;
      sat = 1'b0;
      opc = '0;
      mmp = 1'b0;
      pwd = 1'b0;
    end

    bundle.cnt            = n;
    pending_kind_next     = nk;
    number_accum_next     = acc;
    number_saturated_next = sat;
    pending_op_char_next  = opc;
    prev_was_digit_next   = pwd;
    minus_may_pair_next   = mmp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_kind     <= P_NONE;
      number_accum     <= '0;
      number_saturated <= 1'b0;
      pending_op_char  <= '0;
      prev_was_digit   <= 1'b0;
      minus_may_pair   <= 1'b0;
    end else if (accept) begin
      pending_kind     <= pending_kind_next;
      number_accum     <= number_accum_next;
      number_saturated <= number_saturated_next;
      pending_op_char  <= pending_op_char_next;
      prev_was_digit   <= prev_was_digit_next;
      minus_may_pair   <= minus_may_pair_next;
    end
  end

endmodule

[sv/ect_fifo.sv]
// ----------------------------------------------------------------------------
// ect_fifo
// Short queue of token bundles between the lexer and the output sequencer.
// ----------------------------------------------------------------------------
module ect_fifo #(
  parameter int DEPTH = ect_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ect_pkg::bundle_t wr_data,
  output logic             not_full,
  input  logic             pop,
  output ect_pkg::bundle_t rd_data,
  output logic             not_empty
);
  import ect_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  bundle_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CW-1:0]    count;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/ect_back.sv]
// ----------------------------------------------------------------------------
// ect_back
// Output sequencer: walks the head bundle and sends one token per transfer
// through a registered output stage.
// ----------------------------------------------------------------------------
module ect_back (
  input  logic             clk,
  input  logic             rst,
  input  ect_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             pop,
  ect_token_if.source      tokens
);
  import ect_pkg::*;

  logic [CNT_W-1:0] idx;
  logic             out_valid;
  token_t           out_tok;
  logic             load;

  assign load = !out_valid || tokens.ready;
  assign pop  = load && head_valid && (idx == head.cnt - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= pop ? '0 : idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_tok <= head.tok[idx];
    end
  end

  assign tokens.valid        = out_valid;
  assign tokens.kind         = out_tok.kind;
  assign tokens.number_value = out_tok.number_value;
  assign tokens.op_first     = out_tok.op_first;
  assign tokens.op_second    = out_tok.op_second;
  assign tokens.overflow     = out_tok.overflow;
  assign tokens.last_token   = out_tok.last_token;

endmodule

[sv/expression_char_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// expression_char_tokenizer_top
// Infix expression lexer: characters in, number and operator tokens out.
// ----------------------------------------------------------------------------
// A character is accepted in every cycle while the bundle queue between the
// lexer and the output sequencer has room (QUEUE_DEPTH bundles). Each
// character yields zero to three tokens; the output stage sends one token per
// cycle while the receiver is ready, so the output port is the limit on
// streams rich in tokens. A token completed by a character passes through the
// queue memory and then the registered output stage before it appears on the
// output. After end_of_text the lexer starts a fresh expression.
module expression_char_tokenizer_top #(
  parameter int QUEUE_DEPTH = ect_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  ect_char_if.sink    chars,
  ect_token_if.source tokens
);
  import ect_pkg::*;

  logic    push;
  logic    q_ready;
  logic    pop;
  logic    head_valid;
  bundle_t bundle;
  bundle_t head;

  ect_front u_front (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .q_ready (q_ready),
    .push    (push),
    .bundle  (bundle)
  );

  ect_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (bundle),
    .not_full  (q_ready),
    .pop       (pop),
    .rd_data   (head),
    .not_empty (head_valid)
  );

  ect_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .tokens     (tokens)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> q_ready)
    else $error("bundle pushed into full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && head.cnt != '0)
    else $error("pop of empty or zero-length bundle");

  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.last_token |-> tokens.kind == KIND_END)
    else $error("last_token on a token that is not an end token");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    tokens.valid && !tokens.ready |=> tokens.valid && $stable(tokens.number_value))
    else $error("stalled token changed");

endmodule
